// File: hdl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types, constants and window decode functions for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package ufd_pkg;

   localparam int ByteW      = 8;
   localparam int CpW        = 21;
   localparam int WinDepth   = 4;
   localparam int WinIdxW    = $clog2(WinDepth);
   localparam int CntW       = $clog2(WinDepth + 1);
   localparam int QueueDepth = 2;

   localparam logic [1:0] ACT_WAIT = 2'd0;
   localparam logic [1:0] ACT_EMIT = 2'd1;
   localparam logic [1:0] ACT_DROP = 2'd2;

   typedef logic [WinDepth-1:0][ByteW-1:0] win_type;
   typedef logic [CntW-1:0]                cnt_type;

   typedef struct packed {
      logic [1:0]     act;
      cnt_type        len;
      logic [CpW-1:0] cp;
   } step_type;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             last;
   } qitem_type;

   typedef struct packed {
      logic      valid;
      qitem_type item;
   } qhead_type;

   // Decide what to do with the byte at the front of the window.
   function automatic step_type classify(win_type w, cnt_type cnt);
      step_type   s;
      logic [7:0] lead;
      logic [1:0] extra;
      logic       is_seq;
      logic       ok;
      s.act  = ACT_WAIT;
      s.len  = cnt_type'(1);
      s.cp   = '0;
      lead   = w[0];
      extra  = 2'd0;
      is_seq = 1'b0;
      ok     = 1'b1;
      if (cnt != '0) begin
         if (!lead[7]) begin
            s.act = ACT_EMIT;
            s.cp  = CpW'(lead);
         end else if (lead[7:5] == 3'b110) begin
            is_seq = 1'b1;
            extra  = 2'd1;
         end else if (lead[7:4] == 4'b1110) begin
            is_seq = 1'b1;
            extra  = 2'd2;
         end else if (lead[7:3] == 5'b11110) begin
            is_seq = 1'b1;
            extra  = 2'd3;
         end else begin
            s.act = ACT_DROP;
         end
      end
      if (is_seq && (cnt >= cnt_type'(extra) + cnt_type'(1))) begin
         for (int j = 1; j < WinDepth; j++) begin
            if ((j <= int'(extra)) && (w[j][7:6] != 2'b10)) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            s.act = ACT_EMIT;
            s.len = cnt_type'(extra) + cnt_type'(1);
            unique case (extra)
               2'd1: s.cp = CpW'({lead[4:0], w[1][5:0]});
               2'd2: s.cp = CpW'({lead[3:0], w[1][5:0], w[2][5:0]});
               default: s.cp = CpW'({lead[2:0], w[1][5:0], w[2][5:0], w[3][5:0]});
            endcase
         end else begin
            s.act = ACT_DROP;
         end
      end
      return s;
   endfunction

   // Remove n bytes from the front of the window.
   function automatic win_type shift_win(win_type w, cnt_type n);
      return w >> {n, 3'b000};
   endfunction

   // True if the window still gives a code point before it must wait for input.
   function automatic logic yields(win_type w, cnt_type cnt);
      win_type  ww;
      cnt_type  cc;
      step_type s;
      logic     found;
      ww    = w;
      cc    = cnt;
      found = 1'b0;
      for (int i = 0; i < WinDepth - 1; i++) begin
         s = classify(ww, cc);
         if (s.act == ACT_EMIT) begin
            found = 1'b1;
         end
         if (s.act != ACT_WAIT) begin
            ww = shift_win(ww, s.len);
            cc = cc - s.len;
         end
      end
      return found;
   endfunction

endpackage

// File: hdl/utf8_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream into code points.
// ----------------------------------------------------------------------------
// Each request carries one byte and an end-of-stream flag; each response
// carries one code point, with rsp_run_last high on the last code point that
// a request produces. Requests go into a small queue (QUEUE_DEPTH entries)
// ahead of the decode engine, which holds up to four bytes of the current
// sequence and does one action per cycle: emit a code point, or drop one
// byte. The engine takes the next byte in the same cycle as the last action
// of the current one. A well-formed stream and stray bytes sustain one byte
// per cycle; after a bad trail the engine drops the lead and rescans the
// bytes behind it, taking one action for every further code point, and a
// response held by rsp_ready stalls the engine while the queue fills. An
// accepted byte passes through the queue and the window register before it
// reaches the response register. The end-of-stream flag discards any
// unfinished sequence and the bytes behind its lead, and the next byte
// starts a new stream.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder #(
   parameter int QUEUE_DEPTH = ufd_pkg::QueueDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ufd_pkg::ByteW-1:0] req_in_byte,
   input  logic                      req_in_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ufd_pkg::CpW-1:0]   rsp_code_point,
   output logic                      rsp_run_last
);
   import ufd_pkg::*;

   qhead_type head;
   logic      pop;

   ufd_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in_byte(req_in_byte),
      .req_in_last(req_in_last),
      .pop        (pop),
      .head       (head)
   );

   ufd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_point(rsp_code_point),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// File: hdl/ufd_front.sv
// ----------------------------------------------------------------------------
// ufd_front
// Request side: accepts bytes and queues them for the decode engine.
// ----------------------------------------------------------------------------
module ufd_front #(
   parameter int QUEUE_DEPTH = ufd_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ufd_pkg::ByteW-1:0] req_in_byte,
   input  logic                    req_in_last,
   input  logic                    pop,
   output ufd_pkg::qhead_type      head
);
   import ufd_pkg::*;

   localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FillW = $clog2(QUEUE_DEPTH + 1);

   qitem_type          mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0]   fill_ff, fill_in;
   logic               push;
   logic               do_pop;

   assign req_ready  = (fill_ff != FillW'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head.valid = (fill_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, do_pop})
         2'b10:   fill_in = fill_ff + FillW'(1);
         2'b01:   fill_in = fill_ff - FillW'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{data: req_in_byte, last: req_in_last};
      end
   end

endmodule

// File: hdl/ufd_back.sv
// ----------------------------------------------------------------------------
// ufd_back
// Decode engine: gathers sequences in a four-byte window, emits code points.
// ----------------------------------------------------------------------------
module ufd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ufd_pkg::qhead_type       head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ufd_pkg::CpW-1:0]  rsp_code_point,
   output logic                     rsp_run_last
);
   import ufd_pkg::*;

   win_type        win_ff, win_in;
   cnt_type        cnt_ff, cnt_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CpW-1:0] cp_ff, cp_in;
   logic           run_last_ff, run_last_in;

   step_type cur;
   step_type post;
   win_type  post_win;
   cnt_type  post_cnt;
   win_type  base_win;
   cnt_type  base_cnt;
   logic     out_free;
   logic     emit_go;
   logic     act_go;
   logic     settle;

   always_comb begin
      cur      = classify(win_ff, cnt_ff);
      out_free = !rsp_valid_ff || rsp_ready;
      emit_go  = (cur.act == ACT_EMIT) && out_free;
      act_go   = emit_go || (cur.act == ACT_DROP);
      post_win = shift_win(win_ff, cur.len);
      post_cnt = cnt_ff - cur.len;
      post     = classify(post_win, post_cnt);
      settle   = (cur.act == ACT_WAIT) || (act_go && (post.act == ACT_WAIT));

      base_win = act_go ? post_win : win_ff;
      base_cnt = act_go ? post_cnt : cnt_ff;
      // drop the unfinished tail once the stream ends
      if (settle && last_ff) begin
         base_cnt = '0;
      end

      pop     = settle && head.valid;
      win_in  = base_win;
      cnt_in  = base_cnt;
      last_in = settle ? 1'b0 : last_ff;
      if (pop) begin
         win_in[base_cnt[WinIdxW-1:0]] = head.item.data;
         cnt_in  = base_cnt + cnt_type'(1);
         last_in = head.item.last;
      end

      rsp_valid_in = emit_go ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      cp_in        = emit_go ? cur.cp : cp_ff;
      run_last_in  = emit_go ? !yields(post_win, post_cnt) : run_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      cp_ff       <= cp_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_run_last   = run_last_ff;

endmodule

// File: hdl/ufd_checker.sv
// ----------------------------------------------------------------------------
// ufd_checker
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ufd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [ufd_pkg::ByteW-1:0] req_in_byte,
   input logic                      req_in_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ufd_pkg::CpW-1:0]   rsp_code_point,
   input logic                      rsp_run_last
);
   import ufd_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable(req_in_byte) && $stable(req_in_last))
      else $error("request changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_code_point) && $stable(rsp_run_last))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready right after reset");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response before any request could be decoded");

endmodule

bind utf8_byte_stream_decoder ufd_checker u_ufd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_in_byte   (req_in_byte),
   .req_in_last   (req_in_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code_point(rsp_code_point),
   .rsp_run_last  (rsp_run_last)
);
